@@ sv/w2s_pkg.sv @@
package w2s_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NX_CAP_BITS   = 25;
    localparam int COORD_W       = 32;
    localparam int DOT_W         = 64;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int DIM_W         = 14;
    localparam int MAX_DIM       = 8192;
    localparam int BEHIND_SCALE  = 100000;

    // Clip values whose scaled form still fits in 32 bits.
    localparam logic signed [DOT_W-1:0] BEHIND_HI = 64'sd21474;
    localparam logic signed [DOT_W-1:0] BEHIND_LO = -64'sd21474;

    localparam logic [COORD_W-1:0] SAT_POS = 32'h7fff_ffff;
    localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_A   = 3'd0,
        REG_ROW0_B   = 3'd1,
        REG_ROW1_A   = 3'd2,
        REG_ROW1_B   = 3'd3,
        REG_ROW3_A   = 3'd4,
        REG_ROW3_B   = 3'd5,
        REG_WIDTH    = 3'd6,
        REG_HEIGHT   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic visible;
        logic neg_x;
        logic neg_y;
        logic cap_x;
        logic cap_y;
    } div_flags_t;

endpackage

@@ sv/matrix_world_to_screen_projection.sv @@
// Inputs (Q16.16 by default) pass the dot-product registers, the divider, the pixel
// stage and the output register, one point per cycle while the skid stage is empty;
// the divider is a chain of FRAC_BITS + 25 registered steps, one quotient bit each,
// for clip x and clip y side by side. Reset is asynchronous and active low: valid
// bits clear, the matrix registers return to zero and the viewport to 1920 by 1080.
module matrix_world_to_screen_projection #(
    parameter int FRAC_BITS = w2s_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [3*w2s_pkg::COORD_W-1:0]      s_tdata,   // point_x, point_y, point_z
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [2*w2s_pkg::COORD_W-1:0]      m_tdata,   // screen_x, screen_y
    output logic                               m_tuser,   // visible
    input  logic                               cfg_we,
    input  logic [w2s_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [w2s_pkg::CFG_W-1:0]          cfg_data
);
    import w2s_pkg::*;

    localparam int K = NX_CAP_BITS + FRAC_BITS;

    logic [CFG_W-1:0] row0_a_reg;
    logic [CFG_W-1:0] row0_b_reg;
    logic [CFG_W-1:0] row1_a_reg;
    logic [CFG_W-1:0] row1_b_reg;
    logic [CFG_W-1:0] row3_a_reg;
    logic [CFG_W-1:0] row3_b_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    logic                      en;
    logic                      v1_reg;
    logic                      v2_reg;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [DOT_W-1:0]   cx;
    logic signed [DOT_W-1:0]   cy;
    logic signed [DOT_W-1:0]   cw;

    logic               dv_valid;
    div_flags_t         dv_flags;
    logic [K-1:0]       dv_qx;
    logic [K-1:0]       dv_qy;
    logic [COORD_W-1:0] dv_bx;
    logic [COORD_W-1:0] dv_by;

    logic               p_valid;
    logic [COORD_W-1:0] p_sx;
    logic [COORD_W-1:0] p_sy;
    logic               p_vis;

    logic                 out_valid_reg;
    logic [2*COORD_W-1:0] out_data_reg;
    logic                 out_user_reg;
    logic                 skid_valid_reg;
    logic [2*COORD_W-1:0] skid_data_reg;
    logic                 skid_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_a_reg <= '0;
            row0_b_reg <= '0;
            row1_a_reg <= '0;
            row1_b_reg <= '0;
            row3_a_reg <= '0;
            row3_b_reg <= '0;
            width_reg  <= DIM_W'(1920);
            height_reg <= DIM_W'(1080);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_ROW0_A: row0_a_reg <= cfg_data;
                REG_ROW0_B: row0_b_reg <= cfg_data;
                REG_ROW1_A: row1_a_reg <= cfg_data;
                REG_ROW1_B: row1_b_reg <= cfg_data;
                REG_ROW3_A: row3_a_reg <= cfg_data;
                REG_ROW3_B: row3_b_reg <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // The whole pipeline moves while the skid stage is empty.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    assign px = s_tdata[COORD_W-1:0];
    assign py = s_tdata[2*COORD_W-1:COORD_W];
    assign pz = s_tdata[3*COORD_W-1:2*COORD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    w2s_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_x (
        .clk(clk), .en(en), .coeff_a(row0_a_reg), .coeff_b(row0_b_reg),
        .px(px), .py(py), .pz(pz), .dot(cx)
    );

    w2s_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_y (
        .clk(clk), .en(en), .coeff_a(row1_a_reg), .coeff_b(row1_b_reg),
        .px(px), .py(py), .pz(pz), .dot(cy)
    );

    w2s_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_w (
        .clk(clk), .en(en), .coeff_a(row3_a_reg), .coeff_b(row3_b_reg),
        .px(px), .py(py), .pz(pz), .dot(cw)
    );

    w2s_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2_reg),
        .cx(cx), .cy(cy), .w(cw),
        .out_valid(dv_valid), .flags(dv_flags), .qx(dv_qx), .qy(dv_qy),
        .bx(dv_bx), .by(dv_by)
    );

    w2s_pixel #(.FRAC_BITS(FRAC_BITS)) u_pixel (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(dv_valid),
        .flags(dv_flags), .qx(dv_qx), .qy(dv_qy), .bx(dv_bx), .by(dv_by),
        .screen_width(width_reg), .screen_height(height_reg),
        .out_valid(p_valid), .sx(p_sx), .sy(p_sy), .vis(p_vis)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg  <= skid_valid_reg || p_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (p_valid && en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : {p_sy, p_sx};
            out_user_reg <= skid_valid_reg ? skid_user_reg : p_vis;
        end
        else if (en)
        begin
            skid_data_reg <= {p_sy, p_sx};
            skid_user_reg <= p_vis;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

@@ sv/w2s_dot.sv @@
module w2s_dot #(
    parameter int FRAC_BITS = w2s_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic        [w2s_pkg::CFG_W-1:0]   coeff_a,
    input  logic        [w2s_pkg::CFG_W-1:0]   coeff_b,
    input  logic signed [w2s_pkg::COORD_W-1:0] px,
    input  logic signed [w2s_pkg::COORD_W-1:0] py,
    input  logic signed [w2s_pkg::COORD_W-1:0] pz,
    output logic signed [w2s_pkg::DOT_W-1:0]   dot
);
    import w2s_pkg::*;

    logic signed [COORD_W-1:0] c0;
    logic signed [COORD_W-1:0] c1;
    logic signed [COORD_W-1:0] c2;
    logic signed [COORD_W-1:0] c3;
    logic signed [DOT_W-1:0]   m0;
    logic signed [DOT_W-1:0]   m1;
    logic signed [DOT_W-1:0]   m2;
    logic signed [DOT_W-1:0]   p0_reg;
    logic signed [DOT_W-1:0]   p1_reg;
    logic signed [DOT_W-1:0]   p2_reg;
    logic signed [COORD_W-1:0] c3_reg;
    logic signed [DOT_W-1:0]   dot_reg;

    assign c0 = coeff_a[CFG_W-1:COORD_W];
    assign c1 = coeff_a[COORD_W-1:0];
    assign c2 = coeff_b[CFG_W-1:COORD_W];
    assign c3 = coeff_b[COORD_W-1:0];

    assign m0 = c0 * px;
    assign m1 = c1 * py;
    assign m2 = c2 * pz;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= m0 >>> FRAC_BITS;
            p1_reg  <= m1 >>> FRAC_BITS;
            p2_reg  <= m2 >>> FRAC_BITS;
            c3_reg  <= c3;
            dot_reg <= p0_reg + p1_reg + p2_reg + DOT_W'(c3_reg);
        end
    end

    assign dot = dot_reg;

endmodule

@@ sv/w2s_div.sv @@
module w2s_div #(
    parameter int FRAC_BITS = w2s_pkg::FRAC_BITS_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   en,
    input  logic                                                   in_valid,
    input  logic signed [w2s_pkg::DOT_W-1:0]                       cx,
    input  logic signed [w2s_pkg::DOT_W-1:0]                       cy,
    input  logic signed [w2s_pkg::DOT_W-1:0]                       w,
    output logic                                                   out_valid,
    output w2s_pkg::div_flags_t                                    flags,
    output logic        [w2s_pkg::NX_CAP_BITS+FRAC_BITS-1:0]       qx,
    output logic        [w2s_pkg::NX_CAP_BITS+FRAC_BITS-1:0]       qy,
    output logic        [w2s_pkg::COORD_W-1:0]                     bx,
    output logic        [w2s_pkg::COORD_W-1:0]                     by
);
    import w2s_pkg::*;

    localparam int K = NX_CAP_BITS + FRAC_BITS;
    localparam longint W_MIN = ((longint'(1) << FRAC_BITS) + 999) / 1000;

    logic [DOT_W-1:0]   ux;
    logic [DOT_W-1:0]   uy;
    logic [DOT_W-1:0]   ud;
    div_flags_t         fl_next;
    logic [COORD_W-1:0] bx_next;
    logic [COORD_W-1:0] by_next;

    logic [DOT_W-1:0]       ud_reg [0:K];
    logic [DOT_W-1:0]       rx_reg [0:K];
    logic [DOT_W-1:0]       ry_reg [0:K];
    logic [NX_CAP_BITS-1:0] dx_reg [0:K];
    logic [NX_CAP_BITS-1:0] dy_reg [0:K];
    logic [K-1:0]           qx_reg [0:K];
    logic [K-1:0]           qy_reg [0:K];
    div_flags_t             fl_reg [0:K];
    logic [COORD_W-1:0]     bx_reg [0:K];
    logic [COORD_W-1:0]     by_reg [0:K];
    logic                   v_reg  [0:K];

    always_comb
    begin
        ux = cx[DOT_W-1] ? DOT_W'(-cx) : DOT_W'(cx);
        uy = cy[DOT_W-1] ? DOT_W'(-cy) : DOT_W'(cy);
        ud = DOT_W'(w);
        fl_next.visible = !(w < W_MIN);
        fl_next.neg_x   = cx[DOT_W-1];
        fl_next.neg_y   = cy[DOT_W-1];
        fl_next.cap_x   = (ux >> NX_CAP_BITS) >= ud;
        fl_next.cap_y   = (uy >> NX_CAP_BITS) >= ud;
        priority if (cx > BEHIND_HI)
            bx_next = SAT_POS;
        else if (cx < BEHIND_LO)
            bx_next = SAT_NEG;
        else
            bx_next = COORD_W'(cx * BEHIND_SCALE);
        priority if (cy > BEHIND_HI)
            by_next = SAT_POS;
        else if (cy < BEHIND_LO)
            by_next = SAT_NEG;
        else
            by_next = COORD_W'(cy * BEHIND_SCALE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ud_reg[0] <= ud;
            rx_reg[0] <= ux >> NX_CAP_BITS;
            ry_reg[0] <= uy >> NX_CAP_BITS;
            dx_reg[0] <= ux[NX_CAP_BITS-1:0];
            dy_reg[0] <= uy[NX_CAP_BITS-1:0];
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            fl_reg[0] <= fl_next;
            bx_reg[0] <= bx_next;
            by_reg[0] <= by_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    // One quotient bit per stage; while the cap flag is clear, the remainder stays below the divisor.
    for (genvar k = 1; k <= K; k++)
    begin : g_step
        logic [DOT_W:0] tx;
        logic [DOT_W:0] ty;
        logic [DOT_W:0] dfx;
        logic [DOT_W:0] dfy;
        logic           gx;
        logic           gy;

        assign tx  = {rx_reg[k-1], dx_reg[k-1][NX_CAP_BITS-1]};
        assign ty  = {ry_reg[k-1], dy_reg[k-1][NX_CAP_BITS-1]};
        assign dfx = tx - {1'b0, ud_reg[k-1]};
        assign dfy = ty - {1'b0, ud_reg[k-1]};
        assign gx  = !dfx[DOT_W];
        assign gy  = !dfy[DOT_W];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ud_reg[k] <= ud_reg[k-1];
                rx_reg[k] <= gx ? dfx[DOT_W-1:0] : tx[DOT_W-1:0];
                ry_reg[k] <= gy ? dfy[DOT_W-1:0] : ty[DOT_W-1:0];
                dx_reg[k] <= {dx_reg[k-1][NX_CAP_BITS-2:0], 1'b0};
                dy_reg[k] <= {dy_reg[k-1][NX_CAP_BITS-2:0], 1'b0};
                qx_reg[k] <= {qx_reg[k-1][K-2:0], gx};
                qy_reg[k] <= {qy_reg[k-1][K-2:0], gy};
                fl_reg[k] <= fl_reg[k-1];
                bx_reg[k] <= bx_reg[k-1];
                by_reg[k] <= by_reg[k-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_reg[k-1];
        end
    end

    assign out_valid = v_reg[K];
    assign flags     = fl_reg[K];
    assign qx        = qx_reg[K];
    assign qy        = qy_reg[K];
    assign bx        = bx_reg[K];
    assign by        = by_reg[K];

endmodule

@@ sv/w2s_pixel.sv @@
module w2s_pixel #(
    parameter int FRAC_BITS = w2s_pkg::FRAC_BITS_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             en,
    input  logic                                             in_valid,
    input  w2s_pkg::div_flags_t                              flags,
    input  logic [w2s_pkg::NX_CAP_BITS+FRAC_BITS-1:0]        qx,
    input  logic [w2s_pkg::NX_CAP_BITS+FRAC_BITS-1:0]        qy,
    input  logic [w2s_pkg::COORD_W-1:0]                      bx,
    input  logic [w2s_pkg::COORD_W-1:0]                      by,
    input  logic [w2s_pkg::DIM_W-1:0]                        screen_width,
    input  logic [w2s_pkg::DIM_W-1:0]                        screen_height,
    output logic                                             out_valid,
    output logic [w2s_pkg::COORD_W-1:0]                      sx,
    output logic [w2s_pkg::COORD_W-1:0]                      sy,
    output logic                                             vis
);
    import w2s_pkg::*;

    localparam int K  = NX_CAP_BITS + FRAC_BITS;
    localparam int QW = K + 1;
    localparam int MW = QW + DIM_W;
    localparam int VW = MW + 3;
    localparam logic signed [VW-1:0] HALF  = VW'(1) << FRAC_BITS;
    localparam logic signed [VW-1:0] S_MAX = (VW'(1) << 31) - VW'(1);
    localparam logic signed [VW-1:0] S_MIN = -S_MAX - VW'(1);

    logic [QW-1:0]      qmx;
    logic [QW-1:0]      qmy;
    logic [DIM_W-1:0]   wd;
    logic [DIM_W-1:0]   hd;
    logic [MW-1:0]      mx_reg;
    logic [MW-1:0]      my_reg;
    logic [DIM_W-1:0]   wd_reg;
    logic [DIM_W-1:0]   hd_reg;
    div_flags_t         fl_reg;
    logic [COORD_W-1:0] bx_reg;
    logic [COORD_W-1:0] by_reg;
    logic               v_reg;

    logic signed [VW-1:0] mxs;
    logic signed [VW-1:0] mys;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [VW-1:0] hx;
    logic signed [VW-1:0] hy;

    always_comb
    begin
        qmx = flags.cap_x ? (QW'(1) << K) : {1'b0, qx};
        qmy = flags.cap_y ? (QW'(1) << K) : {1'b0, qy};
        wd  = (screen_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : screen_width;
        hd  = (screen_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : screen_height;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= MW'(qmx) * MW'(wd);
            my_reg <= MW'(qmy) * MW'(hd);
            wd_reg <= wd;
            hd_reg <= hd;
            fl_reg <= flags;
            bx_reg <= bx;
            by_reg <= by;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_comb
    begin
        mxs = $signed(VW'(mx_reg));
        mys = $signed(VW'(my_reg));
        vx  = ($signed(VW'(wd_reg >> 1)) <<< (FRAC_BITS + 1))
            + (fl_reg.neg_x ? -mxs : mxs) + HALF;
        vy  = ($signed(VW'(hd_reg >> 1)) <<< (FRAC_BITS + 1))
            - ((fl_reg.neg_y ? -mys : mys) + HALF);
        hx  = vx >>> 1;
        hy  = vy >>> 1;
        priority if (!fl_reg.visible)
            sx = bx_reg;
        else if (hx > S_MAX)
            sx = SAT_POS;
        else if (hx < S_MIN)
            sx = SAT_NEG;
        else
            sx = hx[COORD_W-1:0];
        priority if (!fl_reg.visible)
            sy = by_reg;
        else if (hy > S_MAX)
            sy = SAT_POS;
        else if (hy < S_MIN)
            sy = SAT_NEG;
        else
            sy = hy[COORD_W-1:0];
    end

    assign vis       = fl_reg.visible;
    assign out_valid = v_reg;

endmodule

@@ sv/w2s_checker.sv @@
module w2s_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [2*w2s_pkg::COORD_W-1:0] m_tdata,
    input logic                          m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result withdrawn before its transfer.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result changed.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("Input stalled while no result is waiting.");

    a_stall_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("Input stalled without a stalled result.");

endmodule

bind matrix_world_to_screen_projection w2s_checker u_w2s_checker (.*);
